// ===== rtl/hcvl_pkg.sv =====
// ----------------------------------------------------------------------------
// hcvl_pkg
// Shared types, codes and position helpers for the variable-length
// Hamming single-error-correcting codec.
// ----------------------------------------------------------------------------
package hcvl_pkg;

  localparam int WORD_W   = 64;
  localparam int SYN_W    = 6;
  localparam int STATUS_W = 2;
  localparam int DBITS_W  = 6;
  localparam int LEN_W    = 7;
  localparam int DATA_MAX = 57;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_CLEAN     = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_REJECTED  = 2'd2
  } status_t;

  // Operation carried with each input beat.
  typedef enum logic {
    ACT_ENCODE = 1'b0,
    ACT_DECODE = 1'b1
  } action_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_DATA_BITS      = 1'b0,
    CFG_CORRECT_ENABLE = 1'b1
  } cfg_index_t;

  // Least r with m + r + 1 <= 2^r, as a short compare chain.
  function automatic logic [2:0] parity_count(input logic [DBITS_W-1:0] m);
    logic [2:0] r;
    if (m <= 6'd1) begin
      r = 3'd2;
    end else if (m <= 6'd4) begin
      r = 3'd3;
    end else if (m <= 6'd11) begin
      r = 3'd4;
    end else if (m <= 6'd26) begin
      r = 3'd5;
    end else if (m <= 6'd57) begin
      r = 3'd6;
    end else begin
      r = 3'd7;
    end
    return r;
  endfunction

  // Largest data width whose codeword fits in code_width bits.
  function automatic int max_data_bits(input int code_width);
    int best;
    best = 1;
    for (int m = 1; m <= DATA_MAX; m++) begin
      if (m + int'(parity_count(DBITS_W'(m))) <= code_width) begin
        best = m;
      end
    end
    return best;
  endfunction

  // Saturate a requested width to 1..57, then to the largest that fits.
  function automatic logic [DBITS_W-1:0] effective_m(input logic [DBITS_W-1:0] v,
                                                     input logic [DBITS_W-1:0] mmax);
    logic [DBITS_W-1:0] m;
    if (v == '0) begin
      m = DBITS_W'(1);
    end else if (v > DBITS_W'(DATA_MAX)) begin
      m = DBITS_W'(DATA_MAX);
    end else begin
      m = v;
    end
    if (m > mmax) begin
      m = mmax;
    end
    return m;
  endfunction

  // True when codeword position i (from 1) carries a data bit.
  function automatic bit is_data_pos(input int i);
    return (i & (i - 1)) != 0;
  endfunction

  // Order of data position i among all data positions, from 0.
  function automatic int data_slot(input int i);
    int slot;
    slot = 0;
    for (int j = 1; j < i; j++) begin
      if (is_data_pos(j)) begin
        slot++;
      end
    end
    return slot;
  endfunction

  // Positions covered by parity check p: bit i-1 set where i has bit p.
  function automatic logic [WORD_W-1:0] check_mask(input int p);
    logic [WORD_W-1:0] mask;
    mask = '0;
    for (int i = 1; i <= WORD_W; i++) begin
      mask[i-1] = ((i >> p) & 1) != 0;
    end
    return mask;
  endfunction

  // Bit reversal of a full word.
  function automatic logic [WORD_W-1:0] reverse_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < WORD_W; i++) begin
      r[i] = w[WORD_W-1-i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/hamming_codec_variable_length_unit.sv =====
// ----------------------------------------------------------------------------
// hamming_codec_variable_length_unit
// Hamming single-error-correcting encoder and decoder with a data width
// of 1 to 57 bits chosen at run time.
//
//   Channel   Direction  Beat contents
//   s_*       in         tuser: action; tdata: word_in
//   m_*       out        tdata: word_out, syndrome, status
//   cfg_*     in         register write: index, data (no read-back)
//
// Each beat passes an input register and a result register; a result is
// offered on m_tvalid once it is loaded into the result register, and one
// beat can be taken every cycle while the output is not stalled. The encode
// and decode paths are single parity trees and shifts between those two
// registers. Stalls on the output side propagate back through the input
// register; s_tready stays high whenever a slot is free.
// Reset (rst, synchronous) empties both stages and sets data_bits to four
// and correct_enable to one.
// ----------------------------------------------------------------------------
module hamming_codec_variable_length_unit #(
  parameter int CODE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] word_in
  input  logic        s_tuser,   // [0] action
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [63:0] word_out, [69:64] syndrome, [71:70] status
  // Configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int W = hcvl_pkg::WORD_W;
  localparam logic [hcvl_pkg::DBITS_W-1:0] MMAX =
    hcvl_pkg::DBITS_W'(hcvl_pkg::max_data_bits(CODE_WIDTH));
  localparam logic [hcvl_pkg::DBITS_W-1:0] RESET_DATA_BITS = hcvl_pkg::DBITS_W'(4);

  // Configuration, held in decoded form.
  logic [hcvl_pkg::DBITS_W-1:0] m_eff;
  logic [W-1:0]                 pos_mask;
  logic [W-1:0]                 data_mask;
  logic                         corr_en;

  logic [hcvl_pkg::DBITS_W-1:0] m_src;
  logic [hcvl_pkg::DBITS_W-1:0] m_next;
  logic [hcvl_pkg::LEN_W-1:0]   n_next;

  // Input stage.
  logic                   in_valid;
  hcvl_pkg::action_t      in_action;
  logic [W-1:0]           in_word;

  // Result stage.
  logic                          out_valid;
  logic [W-1:0]                  out_word;
  logic [hcvl_pkg::SYN_W-1:0]    out_syn;
  hcvl_pkg::status_t             out_status;

  logic out_load;

  // Datapath signals.
  logic [hcvl_pkg::DBITS_W-1:0] sh;
  logic [W-1:0]                 d_rev;
  logic [W-1:0]                 enc_word;
  logic [W-1:0]                 wm;
  logic [hcvl_pkg::SYN_W-1:0]   syn;
  logic [W-1:0]                 wc;
  logic [W-1:0]                 packed_data;
  logic [W-1:0]                 dec_word;
  logic [W-1:0]                 res_word;
  logic [hcvl_pkg::SYN_W-1:0]   res_syn;
  hcvl_pkg::status_t            res_status;

  // Decode a width write (or the reset value) into width and masks.
  always_comb begin
    m_src  = rst ? RESET_DATA_BITS : cfg_data;
    m_next = hcvl_pkg::effective_m(m_src, MMAX);
    n_next = hcvl_pkg::LEN_W'(m_next) + hcvl_pkg::LEN_W'(hcvl_pkg::parity_count(m_next));
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg_we && cfg_index == hcvl_pkg::CFG_DATA_BITS)) begin
      m_eff     <= m_next;
      pos_mask  <= ~({W{1'b1}} << n_next);
      data_mask <= ~({W{1'b1}} << m_next);
    end
    if (rst) begin
      corr_en <= 1'b1;
    end else if (cfg_we && cfg_index == hcvl_pkg::CFG_CORRECT_ENABLE) begin
      corr_en <= cfg_data[0];
    end
  end

  // Handshake: the result register frees a slot, the input stage follows.
  assign out_load = !out_valid || m_tready;
  assign s_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_action <= hcvl_pkg::action_t'(s_tuser);
      in_word   <= s_tdata;
    end
  end

  // Encode: reverse and align the data so slot k holds data bit m-1-k,
  // scatter the slots onto data positions, then fill the check positions.
  always_comb begin
    sh    = hcvl_pkg::DBITS_W'(0) - m_eff;
    d_rev = hcvl_pkg::reverse_word(in_word) >> sh;
    enc_word = '0;
    for (int i = 1; i <= W; i++) begin
      if (hcvl_pkg::is_data_pos(i)) begin
        enc_word[i-1] = d_rev[hcvl_pkg::data_slot(i)];
      end
    end
    for (int p = 0; p < hcvl_pkg::SYN_W; p++) begin
      enc_word[(1 << p) - 1] = ^(enc_word & hcvl_pkg::check_mask(p));
    end
  end

  // Decode: syndrome over the codeword, optional single-bit flip, then
  // gather the data positions back into data bit order.
  always_comb begin
    wm = in_word & pos_mask;
    for (int p = 0; p < hcvl_pkg::SYN_W; p++) begin
      syn[p] = ^(wm & hcvl_pkg::check_mask(p));
    end
    wc = wm;
    if (syn != '0 && corr_en) begin
      wc = wm ^ (W'(1) << (syn - hcvl_pkg::SYN_W'(1)));
    end
    wc = wc & pos_mask;
    packed_data = '0;
    for (int i = 1; i <= W; i++) begin
      if (hcvl_pkg::is_data_pos(i)) begin
        packed_data[hcvl_pkg::data_slot(i)] = wc[i-1];
      end
    end
    dec_word = hcvl_pkg::reverse_word(packed_data & data_mask) >> sh;
  end

  // Result selection.
  always_comb begin
    res_word   = enc_word;
    res_syn    = '0;
    res_status = hcvl_pkg::ST_CLEAN;
    if (in_action == hcvl_pkg::ACT_DECODE) begin
      res_syn  = syn;
      res_word = dec_word;
      if (syn != '0) begin
        if (corr_en) begin
          res_status = hcvl_pkg::ST_CORRECTED;
        end else begin
          res_status = hcvl_pkg::ST_REJECTED;
          res_word   = '0;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
    if (out_load && in_valid) begin
      out_word   <= res_word;
      out_syn    <= res_syn;
      out_status <= res_status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_status, out_syn, out_word};

endmodule
